FILE: design/prdq_pkg.sv
package prdq_pkg;

  localparam int MAX_SESSIONS = 16;
  localparam int ID_W         = 4;
  localparam int ID_SPACE     = 1 << ID_W;
  localparam int TIME_W       = 48;
  localparam int STEP_W       = 16;
  localparam int INTERVAL_W   = 24;
  localparam int COUNT_W      = $clog2(MAX_SESSIONS + 1);
  localparam int CAPACITY     = (MAX_SESSIONS < ID_SPACE) ? MAX_SESSIONS : ID_SPACE;

  localparam logic [STEP_W-1:0]     TICK_STEP_RST       = 16'd10;
  localparam logic [INTERVAL_W-1:0] REPORT_INTERVAL_RST = 24'd5000;

  // APB register map (index taken from paddr[2])
  localparam logic REG_TICK_STEP       = 1'b0;
  localparam logic REG_REPORT_INTERVAL = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_CREATE  = 2'd1,
    CMD_DESTROY = 2'd2
  } cmd_e_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_PRESENT = 2'd2,
    STAT_ABSENT  = 2'd3
  } status_e_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_REQUEUE
  } cell_op_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PREP,
    ST_SCAN
  } state_e_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_e_t          op;
    logic [ID_W-1:0]     key_id;
    logic [ID_W-1:0]     new_id;
    logic [TIME_W-1:0]   new_due;
  } cell_cmd_t;

  // What the chain shows back to the controller.
  typedef struct packed {
    logic                present;
    logic [ID_W-1:0]     head_id;
    logic [TIME_W-1:0]   head_due;
  } chain_stat_t;

endpackage

FILE: design/prdq_cell.sv
module prdq_cell
  import prdq_pkg::*;
(
  input  logic                clk,
  input  logic                head,
  input  logic                in_use,
  input  cell_cmd_t           cmd,
  input  logic [ID_W-1:0]     left_id,
  input  logic [TIME_W-1:0]   left_due,
  input  logic                left_s,
  input  logic                left_p,
  input  logic [ID_W-1:0]     right_id,
  input  logic [TIME_W-1:0]   right_due,
  input  logic                right_s,
  output logic [ID_W-1:0]     id,
  output logic [TIME_W-1:0]   due,
  output logic                s,
  output logic                p
);

  logic                match;
  logic                lt;
  logic [ID_W-1:0]     id_next;
  logic [TIME_W-1:0]   due_next;

  // s: some entry at or right of this one is earlier than the new due time.
  // p: the key id sits at or left of this one.
  assign match = in_use && (id == cmd.key_id);
  assign lt    = in_use && (due < cmd.new_due);
  assign s     = lt | right_s;
  assign p     = match | left_p;

  always_comb begin
    id_next  = id;
    due_next = due;
    case (cmd.op)
      OP_INSERT: begin
        if (!s) begin
          if (left_s) begin
            id_next  = cmd.new_id;
            due_next = cmd.new_due;
          end else begin
            id_next  = left_id;
            due_next = left_due;
          end
        end
      end
      OP_REQUEUE: begin
        // head leaves; entries before the slot slide left, the slot takes the head
        if (right_s) begin
          id_next  = right_id;
          due_next = right_due;
        end else if (head || s) begin
          id_next  = cmd.new_id;
          due_next = cmd.new_due;
        end
      end
      OP_REMOVE: begin
        if (p) begin
          id_next  = right_id;
          due_next = right_due;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    id  <= id_next;
    due <= due_next;
  end

endmodule

FILE: design/prdq_ctrl.sv
module prdq_ctrl
  import prdq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              command,
  input  logic [ID_W-1:0]         session_id,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic                    report_valid,
  output logic [ID_W-1:0]         report_session,
  output logic                    last,
  input  logic [STEP_W-1:0]       tick_step,
  input  logic [INTERVAL_W-1:0]   report_interval,
  input  chain_stat_t             chain,
  output cell_cmd_t               cell_cmd,
  output logic [COUNT_W-1:0]      count
);

  state_e_t              state, state_next;
  cmd_e_t                cmd_q, cmd_q_next;
  logic [ID_W-1:0]       id_q, id_q_next;
  logic [TIME_W-1:0]     cur_time, cur_time_next;
  logic [TIME_W-1:0]     new_due;
  logic [COUNT_W-1:0]    count_next;
  logic [COUNT_W-1:0]    budget, budget_next;
  logic                  pend_valid, pend_valid_next;
  logic [ID_W-1:0]       pend_id, pend_id_next;
  logic                  out_valid_next;
  status_e_t             out_status, out_status_next;
  logic                  out_rvalid, out_rvalid_next;
  logic [ID_W-1:0]       out_rsession, out_rsession_next;
  logic                  out_last, out_last_next;
  logic                  out_free;
  logic                  more;

  assign out_free = !out_valid || out_ready;
  assign more     = (budget != '0) && (chain.head_due <= cur_time);

  assign status         = out_status;
  assign report_valid   = out_rvalid;
  assign report_session = out_rsession;
  assign last           = out_last;

  always_comb begin
    state_next        = state;
    cmd_q_next        = cmd_q;
    id_q_next         = id_q;
    cur_time_next     = cur_time;
    count_next        = count;
    budget_next       = budget;
    pend_valid_next   = pend_valid;
    pend_id_next      = pend_id;
    out_valid_next    = out_valid && !out_ready;
    out_status_next   = out_status;
    out_rvalid_next   = out_rvalid;
    out_rsession_next = out_rsession;
    out_last_next     = out_last;
    in_ready          = 1'b0;
    cell_cmd.op       = OP_HOLD;
    cell_cmd.key_id   = id_q;
    cell_cmd.new_id   = id_q;
    cell_cmd.new_due  = new_due;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_q_next = cmd_e_t'(command);
          id_q_next  = session_id;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_q)
          CMD_TICK: begin
            if (count == '0) begin
              state_next = ST_IDLE;
            end else begin
              cur_time_next   = cur_time + TIME_W'(tick_step);
              budget_next     = count;
              pend_valid_next = 1'b0;
              state_next      = ST_PREP;
            end
          end
          CMD_CREATE: begin
            if (out_free) begin
              out_valid_next    = 1'b1;
              out_rvalid_next   = 1'b0;
              out_rsession_next = '0;
              out_last_next     = 1'b1;
              if (chain.present) begin
                out_status_next = STAT_PRESENT;
              end else if (count >= COUNT_W'(CAPACITY)) begin
                out_status_next = STAT_FULL;
              end else begin
                out_status_next = STAT_OK;
                cell_cmd.op     = OP_INSERT;
                count_next      = count + COUNT_W'(1);
              end
              state_next = ST_IDLE;
            end
          end
          CMD_DESTROY: begin
            if (out_free) begin
              out_valid_next    = 1'b1;
              out_rvalid_next   = 1'b0;
              out_rsession_next = '0;
              out_last_next     = 1'b1;
              if (!chain.present) begin
                out_status_next = STAT_ABSENT;
              end else begin
                out_status_next = STAT_OK;
                cell_cmd.op     = OP_REMOVE;
                count_next      = count - COUNT_W'(1);
              end
              state_next = ST_IDLE;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_PREP: begin
        // let new_due pick up the advanced time
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!pend_valid || out_free) begin
          if (pend_valid) begin
            out_valid_next    = 1'b1;
            out_status_next   = STAT_OK;
            out_rvalid_next   = 1'b1;
            out_rsession_next = pend_id;
            out_last_next     = !more;
          end
          if (more) begin
            cell_cmd.op     = OP_REQUEUE;
            cell_cmd.new_id = chain.head_id;
            pend_id_next    = chain.head_id;
            pend_valid_next = 1'b1;
            budget_next     = budget - COUNT_W'(1);
          end else begin
            pend_valid_next = 1'b0;
            state_next      = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur_time   <= '0;
      count      <= '0;
      budget     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cur_time   <= cur_time_next;
      count      <= count_next;
      budget     <= budget_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q        <= cmd_q_next;
    id_q         <= id_q_next;
    pend_id      <= pend_id_next;
    new_due      <= cur_time + TIME_W'(report_interval);
    out_status   <= out_status_next;
    out_rvalid   <= out_rvalid_next;
    out_rsession <= out_rsession_next;
    out_last     <= out_last_next;
  end

endmodule

FILE: design/periodic_report_deadline_queue.sv
// Periodic report deadline queue: session ids kept in due-time order.
//
// Input channel (in_valid/in_ready) takes one word per command: a tick, a
// create or a destroy of a session_id. Output channel (out_valid/out_ready)
// delivers result words: one status word per create or destroy, and one
// report word per due session on a tick; last marks the final word of a
// command. A tick on an empty table or with nothing due yields no word.
//
// A create or destroy result is registered once the output register is free.
// A tick advances time in ST_EXEC, lets new_due pick it up in ST_PREP, then
// pops and requeues one due head per cycle while the output register is
// free; the next command is taken once the current one is finished. The
// rate is set by the cell chain, which performs one insert, remove or
// requeue shift per cycle.
//
// The output word sits in a register: a command can be taken while the
// previous result still waits, and a stalled receiver holds all further
// work. Reset (rst, synchronous) empties the table, zeroes the clock and
// restores tick_step = 10 and report_interval = 5000; no clearing pass.
// Registers: tick_step at byte 0x0, report_interval at 0x4 (APB, write or read).
module periodic_report_deadline_queue
  import prdq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          command,
  input  logic [ID_W-1:0]     session_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic                report_valid,
  output logic [ID_W-1:0]     report_session,
  output logic                last
);

  logic [STEP_W-1:0]      tick_step;
  logic [INTERVAL_W-1:0]  report_interval;
  cell_cmd_t              cell_cmd;
  chain_stat_t            chain;
  logic [COUNT_W-1:0]     count;

  // Cell row: index 0 is the head (earliest due time).
  logic [ID_W-1:0]        cell_id  [MAX_SESSIONS];
  logic [TIME_W-1:0]      cell_due [MAX_SESSIONS];
  logic                   cell_s   [MAX_SESSIONS];
  logic                   cell_p   [MAX_SESSIONS];

  // Configuration port: no wait states, low address bits ignored.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step       <= TICK_STEP_RST;
      report_interval <= REPORT_INTERVAL_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_TICK_STEP:       tick_step       <= pwdata[STEP_W-1:0];
        REG_REPORT_INTERVAL: report_interval <= pwdata[INTERVAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TICK_STEP:       prdata = 32'(tick_step);
      REG_REPORT_INTERVAL: prdata = 32'(report_interval);
      default:             prdata = '0;
    endcase
  end

  prdq_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .session_id      (session_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .report_valid    (report_valid),
    .report_session  (report_session),
    .last            (last),
    .tick_step       (tick_step),
    .report_interval (report_interval),
    .chain           (chain),
    .cell_cmd        (cell_cmd),
    .count           (count)
  );

  // Chain: s ripples from the tail toward the head, p from the head to the tail.
  for (genvar i = 0; i < MAX_SESSIONS; i++) begin : g_cell
    localparam logic [COUNT_W-1:0] IDX = COUNT_W'(i);
    logic                left_s, left_p, right_s;
    logic [ID_W-1:0]     left_id, right_id;
    logic [TIME_W-1:0]   left_due, right_due;

    if (i == 0) begin : g_head
      assign left_s   = 1'b1;
      assign left_p   = 1'b0;
      assign left_id  = cell_id[i];
      assign left_due = cell_due[i];
    end else begin : g_mid
      assign left_s   = cell_s[i-1];
      assign left_p   = cell_p[i-1];
      assign left_id  = cell_id[i-1];
      assign left_due = cell_due[i-1];
    end

    if (i == MAX_SESSIONS - 1) begin : g_tail
      assign right_s   = 1'b0;
      assign right_id  = cell_id[i];
      assign right_due = cell_due[i];
    end else begin : g_body
      assign right_s   = cell_s[i+1];
      assign right_id  = cell_id[i+1];
      assign right_due = cell_due[i+1];
    end

    prdq_cell u_cell (
      .clk       (clk),
      .head      (i == 0),
      .in_use    (IDX < count),
      .cmd       (cell_cmd),
      .left_id   (left_id),
      .left_due  (left_due),
      .left_s    (left_s),
      .left_p    (left_p),
      .right_id  (right_id),
      .right_due (right_due),
      .right_s   (right_s),
      .id        (cell_id[i]),
      .due       (cell_due[i]),
      .s         (cell_s[i]),
      .p         (cell_p[i])
    );
  end

  assign chain.present  = cell_p[MAX_SESSIONS-1];
  assign chain.head_id  = cell_id[0];
  assign chain.head_due = cell_due[0];

endmodule

FILE: design/prdq_check.sv
module prdq_check
  import prdq_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       status,
  input logic             report_valid,
  input logic [ID_W-1:0]  report_session,
  input logic             last
);

  // Hold a stalled word.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(report_valid)
      && $stable(report_session) && $stable(last))
    else $error("stalled result word changed");

  a_report_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_valid |-> status == STAT_OK)
    else $error("report word with nonzero status");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !report_valid |-> last && report_session == '0)
    else $error("status word not single or carries a session");

  a_no_report_after_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last ##1 out_valid |-> report_valid)
    else $error("report sequence broken by a status word");

endmodule

bind periodic_report_deadline_queue prdq_check u_prdq_check (.*);

FILE: bench/tb_periodic_report_deadline_queue.sv
`timescale 1ns / 1ps

module tb_periodic_report_deadline_queue;
  import prdq_pkg::*;

  // Command 3 has no meaning: the block takes the word and drops it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Quiet time after the last owed word before touching a register. A tick
  // that reports nothing may still be walking the chain at that point.
  localparam int SETTLE_CYCLES = 2 * MAX_SESSIONS + 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SHOW_LIMIT    = 10;

  // One result word as the block should present it.
  typedef struct packed {
    status_e_t       status;
    logic            rvalid;
    logic [ID_W-1:0] rsess;
    logic            last;
  } result_word_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          command;
  logic [ID_W-1:0]     session_id;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          status;
  logic                report_valid;
  logic [ID_W-1:0]     report_session;
  logic                last;

  // Words the block still owes, oldest first.
  result_word_t        owed_words[$];
  int                  mismatch_count = 0;
  // Set to run both sides of the bench with no idling at all.
  bit                  quiet = 1'b0;

  // Own copy of the deadline table, kept in due order.
  logic [TIME_W-1:0]     clock_now;
  logic [ID_W-1:0]       sess_id  [MAX_SESSIONS];
  logic [TIME_W-1:0]     sess_due [MAX_SESSIONS];
  int                    sess_count;
  logic [STEP_W-1:0]     step_cfg;
  logic [INTERVAL_W-1:0] interval_cfg;

  periodic_report_deadline_queue DUT (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .session_id     (session_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .report_valid   (report_valid),
    .report_session (report_session),
    .last           (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Table model
  // ---------------------------------------------------------------------

  // Return the table position of a session, or -1 when it is absent.
  function automatic int find_session(logic [ID_W-1:0] id);
    for (int i = 0; i < sess_count; i++)
      if (sess_id[i] == id) return i;
    return -1;
  endfunction

  // Close the gap left by a removed entry.
  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < sess_count; i++) begin
      sess_id[i]  = sess_id[i + 1];
      sess_due[i] = sess_due[i + 1];
    end
    sess_count--;
  endfunction

  // Insert after the last entry due strictly earlier, so that a new entry
  // goes ahead of any with the same due time. The sum wraps at 48 bits.
  function automatic void schedule_entry(logic [ID_W-1:0] id);
    logic [TIME_W-1:0] due;
    int pos;
    due = clock_now + TIME_W'(interval_cfg);
    pos = 0;
    for (int i = sess_count; i > 0; i--) begin
      if (sess_due[i - 1] < due) begin
        pos = i;
        break;
      end
    end
    for (int i = sess_count; i > pos; i--) begin
      sess_id[i]  = sess_id[i - 1];
      sess_due[i] = sess_due[i - 1];
    end
    sess_id[pos]  = id;
    sess_due[pos] = due;
    sess_count++;
  endfunction

  // Advance the table by one accepted command and queue the words it owes.
  function automatic void apply_command(logic [1:0] cmd, logic [ID_W-1:0] id);
    int           budget;
    bit           have_word;
    result_word_t word;
    logic [ID_W-1:0] head;
    have_word = 1'b0;
    case (cmd)
      CMD_TICK: begin
        // An empty table holds the clock still.
        if (sess_count > 0) begin
          clock_now = clock_now + TIME_W'(step_cfg);
          // Cap the pops at the starting population: with a zero interval a
          // requeued head would be due again at once.
          budget = sess_count;
          while (budget > 0 && sess_count > 0 && sess_due[0] <= clock_now) begin
            head = sess_id[0];
            drop_entry(0);
            schedule_entry(head);
            if (have_word) owed_words.push_back(word);
            word = '{status: STAT_OK, rvalid: 1'b1, rsess: head, last: 1'b0};
            have_word = 1'b1;
            budget--;
          end
          if (have_word) begin
            word.last = 1'b1;
            owed_words.push_back(word);
          end
        end
      end
      CMD_CREATE: begin
        // A duplicate wins over a full table.
        if (find_session(id) >= 0) begin
          word = '{status: STAT_PRESENT, rvalid: 1'b0, rsess: '0, last: 1'b1};
        end else if (sess_count >= CAPACITY) begin
          word = '{status: STAT_FULL, rvalid: 1'b0, rsess: '0, last: 1'b1};
        end else begin
          schedule_entry(id);
          word = '{status: STAT_OK, rvalid: 1'b0, rsess: '0, last: 1'b1};
        end
        owed_words.push_back(word);
      end
      CMD_DESTROY: begin
        if (find_session(id) < 0) begin
          word = '{status: STAT_ABSENT, rvalid: 1'b0, rsess: '0, last: 1'b1};
        end else begin
          drop_entry(find_session(id));
          word = '{status: STAT_OK, rvalid: 1'b0, rsess: '0, last: 1'b1};
        end
        owed_words.push_back(word);
      end
      default: begin
        // Unused code: no word, no change.
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driving tasks; each one starts and ends at a falling edge
  // ---------------------------------------------------------------------

  // Write one register over APB: setup cycle, then access cycle, then the bus
  // is released and left idle.
  task automatic write_reg(input logic index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (index == REG_TICK_STEP) step_cfg = value[STEP_W-1:0];
    else interval_cfg = value[INTERVAL_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one command word and model it at the edge that takes it. Valid
  // stays high into the next word when no gap is drawn.
  task automatic send_word(input logic [1:0] cmd, input logic [ID_W-1:0] id);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    session_id <= id;
    do @(posedge clk); while (!in_ready);
    apply_command(cmd, id);
    @(negedge clk);
  endtask

  // Drop valid, hold until every owed word has come, then let a tick that
  // reports nothing finish its walk.
  task automatic drain_queue();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (owed_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // Receiver: stall a random number of cycles before each word.
  initial begin : result_ready
    int hold;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Compare every taken word with the oldest one owed.
  always @(posedge clk) begin
    result_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (owed_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
          $display("unexpected word: status %0d report_valid %0d session %0d last %0d",
                   status, report_valid, report_session, last);
      end else begin
        want = owed_words.pop_front();
        if (status !== want.status || report_valid !== want.rvalid ||
            report_session !== want.rsess || last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display({"word mismatch: status %0d/%0d report_valid %0d/%0d ",
                      "session %0d/%0d last %0d/%0d (exp/act)"},
                     want.status, status, want.rvalid, report_valid,
                     want.rsess, report_session, want.last, last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Tick on an empty table, an unused code and a destroy of an absent id.
  task automatic test_idle_commands();
    send_word(CMD_TICK, 4'd0);
    send_word(CMD_UNUSED, 4'd15);
    send_word(CMD_DESTROY, 4'd15);
    drain_queue();
  endtask

  // Fill every slot at one instant: equal due times, each new entry at the
  // head. Then a duplicate on the full table and a tick that pops all.
  task automatic test_full_table();
    write_reg(REG_TICK_STEP, 32'd65535);
    write_reg(REG_REPORT_INTERVAL, 32'd1);
    for (int i = 0; i < MAX_SESSIONS; i++)
      send_word(CMD_CREATE, ID_W'(i));
    send_word(CMD_CREATE, 4'd0);
    send_word(CMD_TICK, 4'd9);
    drain_queue();
  endtask

  // Zero interval: every requeued head is due again at once, so the pop
  // budget alone ends the tick.
  task automatic test_zero_interval();
    write_reg(REG_REPORT_INTERVAL, 32'd0);
    send_word(CMD_TICK, 4'd0);
    drain_queue();
  endtask

  // A step of one with the longest interval: one tick pops the whole table
  // and pushes it far out, the next advances the clock with nothing due.
  task automatic test_nothing_due();
    write_reg(REG_TICK_STEP, 32'd1);
    write_reg(REG_REPORT_INTERVAL, 32'd16777215);
    send_word(CMD_TICK, 4'd0);
    send_word(CMD_TICK, 4'd15);
    send_word(CMD_DESTROY, 4'd7);
    drain_queue();
  endtask

  // Random traffic under one setting. Destroys mostly name live sessions so
  // the table churns; unused codes are sprinkled in and not counted.
  task automatic test_random_traffic(input logic [31:0] step, input logic [31:0] interval,
                                     input int words, input bit calm);
    int              sent;
    int              pick;
    logic [1:0]      cmd;
    logic [ID_W-1:0] id;
    write_reg(REG_TICK_STEP, step);
    write_reg(REG_REPORT_INTERVAL, interval);
    quiet = calm;
    sent = 0;
    while (sent < words) begin
      pick = $urandom_range(0, 99);
      id   = ID_W'($urandom_range(0, ID_SPACE - 1));
      if (pick < 4) begin
        send_word(CMD_UNUSED, id);
      end else begin
        if (pick < 49) cmd = CMD_TICK;
        else if (pick < 79) cmd = CMD_CREATE;
        else cmd = CMD_DESTROY;
        if (cmd == CMD_DESTROY && sess_count > 0 && $urandom_range(0, 3) != 0)
          id = sess_id[$urandom_range(0, sess_count - 1)];
        send_word(cmd, id);
        sent++;
      end
    end
    drain_queue();
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin : run_tests
    logic [31:0] step;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    command    = CMD_TICK;
    session_id = '0;
    // Model the reset state of the table and the registers.
    clock_now    = '0;
    sess_count   = 0;
    step_cfg     = TICK_STEP_RST;
    interval_cfg = REPORT_INTERVAL_RST;
    for (int i = 0; i < MAX_SESSIONS; i++) begin
      sess_id[i]  = '0;
      sess_due[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_idle_commands();
    test_full_table();
    test_zero_interval();
    test_nothing_due();

    // Random phases, extremes first; one phase runs with no idling.
    test_random_traffic(32'd1, 32'd1, 30, 1'b0);
    test_random_traffic(32'd65535, 32'd16777215, 20, 1'b0);
    step = $urandom_range(1, 2000);
    test_random_traffic(step, step * $urandom_range(1, 6) + $urandom_range(0, 100), 30, 1'b1);
    test_random_traffic($urandom_range(1, 65535), $urandom_range(1, 16777215), 20, 1'b0);
    test_random_traffic(32'd100, 32'd300, 20, 1'b0);

    if (mismatch_count == 0 && owed_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin : run_limit
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
design/prdq_pkg.sv
design/prdq_cell.sv
design/prdq_ctrl.sv
design/periodic_report_deadline_queue.sv
design/prdq_check.sv
bench/tb_periodic_report_deadline_queue.sv
